FILE: hdl/tlbpt_pkg.sv
package tlbpt_pkg;

	// Geometry
	localparam int TLB_ENTRIES  = 16;
	localparam int PAGE_COUNT   = 256;
	localparam int FRAME_TOTAL  = 128;
	localparam int OFFSET_WIDTH = 8;

	// Port widths
	localparam int VA_WIDTH = 16;
	localparam int PA_WIDTH = 15;

	// Derived widths
	localparam int PAGE_W  = $clog2(PAGE_COUNT);
	localparam int FRAME_W = $clog2(FRAME_TOTAL);
	localparam int SLOT_W  = $clog2(TLB_ENTRIES);

	// TLB update request from the translate stage
	typedef struct packed {
		logic              fill;     // write at the FIFO fill pointer
		logic              rewrite;  // overwrite the slot of an evicted page
		logic [SLOT_W-1:0] slot;
		logic [PAGE_W-1:0] page;
		logic [FRAME_W-1:0] frame;
	} tlb_upd_t;

	// TLB lookup results
	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic               old_hit;
		logic [SLOT_W-1:0]  old_slot;
	} tlb_rsp_t;

endpackage

FILE: hdl/tlbpt_va_if.sv
interface tlbpt_va_if import tlbpt_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [VA_WIDTH-1:0] virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink (input valid, input virtual_address, output ready);

endinterface

FILE: hdl/tlbpt_pa_if.sv
interface tlbpt_pa_if import tlbpt_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [PA_WIDTH-1:0] physical_address;
	logic                tlb_hit;
	logic                fault_flag;

	modport source (output valid, output physical_address, output tlb_hit,
		output fault_flag, input ready);
	modport sink (input valid, input physical_address, input tlb_hit,
		input fault_flag, output ready);

endinterface

FILE: hdl/tlbpt_ram.sv
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/tlbpt_tlb.sv
module tlbpt_tlb import tlbpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PAGE_W-1:0] lk_page,
	input  logic [PAGE_W-1:0] old_page,
	input  tlb_upd_t          upd,
	output tlb_rsp_t          rsp
);

	logic [TLB_ENTRIES-1:0] valid_q;
	logic [PAGE_W-1:0]      page_q  [TLB_ENTRIES];
	logic [FRAME_W-1:0]     frame_q [TLB_ENTRIES];
	logic [SLOT_W-1:0]      fill_ptr_q;
	logic [SLOT_W-1:0]      hit_slot;

	// Fully associative compare; lowest matching slot wins
	always_comb begin
		rsp.hit      = 1'b0;
		rsp.old_hit  = 1'b0;
		rsp.old_slot = '0;
		hit_slot     = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && page_q[i] == lk_page) begin
				rsp.hit  = 1'b1;
				hit_slot = SLOT_W'(i);
			end
			if (valid_q[i] && page_q[i] == old_page) begin
				rsp.old_hit  = 1'b1;
				rsp.old_slot = SLOT_W'(i);
			end
		end
		rsp.frame = frame_q[hit_slot];
	end

	// Valid bits and FIFO fill pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fill_ptr_q <= '0;
		end else if (upd.fill) begin
			valid_q[fill_ptr_q] <= 1'b1;
			fill_ptr_q <= (fill_ptr_q == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_q + 1'b1;
		end
	end

	// Entry contents
	always_ff @(posedge clk) begin
		if (upd.fill) begin
			page_q[fill_ptr_q]  <= upd.page;
			frame_q[fill_ptr_q] <= upd.frame;
		end else if (upd.rewrite) begin
			page_q[upd.slot]  <= upd.page;
			frame_q[upd.slot] <= upd.frame;
		end
	end

endmodule

FILE: hdl/tlb_page_table_translator.sv
// Virtual to physical address translator with a 16-entry TLB.
//
// req (sink): one word per virtual address; upper 8 bits are the page,
//   lower 8 bits the offset.
// rsp (source): one word per request, in order: physical address plus
//   tlb_hit and fault_flag bits.
// A word taken on req is held in the input stage and then in the result
// register, from which it is offered on rsp. One request is taken every
// cycle while rsp does not stall: the page map and frame owner tables sit
// in RAMs with a registered read port, read as the address is taken and
// used in the input stage, with a one-deep write bypass for the page map.
// The result register takes a new word while the old one is being read
// out; when rsp stalls, one word waits in the result register and one in
// the input stage, then req.ready drops.
// Reset clears TLB valid bits, all page map valid bits, the FIFO fill
// pointer and the round-robin frame counter; no clearing pass is needed.
module tlb_page_table_translator import tlbpt_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	tlbpt_va_if.sink    req,
	tlbpt_pa_if.source  rsp
);

	// Input stage
	logic                s1_valid_q;
	logic [VA_WIDTH-1:0] va_s1;
	logic                s1_fire;
	logic                accept;

	// Result register
	logic                out_valid_q;
	logic [PA_WIDTH-1:0] pa_s2;
	logic                hit_s2;
	logic                fault_s2;

	// Allocation state
	logic [PAGE_COUNT-1:0] map_valid_q;
	logic [FRAME_W-1:0]    next_frame_q;
	logic [FRAME_W-1:0]    next_frame_inc;
	logic [FRAME_W-1:0]    next_frame_d;
	logic                  frames_full_q;

	// Page map write bypass
	logic                  fwd_valid_q;
	logic [PAGE_W-1:0]     fwd_page_q;
	logic [FRAME_W-1:0]    fwd_frame_q;

	// Stage 1 datapath
	logic [PAGE_W-1:0]       req_page;
	logic [PAGE_W-1:0]       page_s1;
	logic [OFFSET_WIDTH-1:0] offset_s1;
	logic [PAGE_W-1:0]       pm_raddr;
	logic [FRAME_W-1:0]      pm_rdata;
	logic [FRAME_W-1:0]      pm_frame;
	logic [PAGE_W-1:0]       old_page;
	logic                    mapped;
	logic                    fault;
	logic                    pm_we;
	logic [FRAME_W-1:0]      frame;
	logic [FRAME_W+OFFSET_WIDTH-1:0] pa_full;
	tlb_upd_t                tlb_upd;
	tlb_rsp_t                tlb_rsp;

	// Handshake
	assign s1_fire   = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_fire;
	assign accept    = req.valid && req.ready;

	assign req_page  = PAGE_W'(req.virtual_address >> OFFSET_WIDTH);
	assign page_s1   = PAGE_W'(va_s1 >> OFFSET_WIDTH);
	assign offset_s1 = va_s1[OFFSET_WIDTH-1:0];

	// Page map read: new page on accept, else re-read the held page
	assign pm_raddr = accept ? req_page : page_s1;
	assign pm_frame = (fwd_valid_q && fwd_page_q == page_s1) ? fwd_frame_q : pm_rdata;

	// Translate
	assign mapped = map_valid_q[page_s1];
	assign fault  = !tlb_rsp.hit && !mapped;
	assign pm_we  = s1_fire && fault;

	always_comb begin
		if (tlb_rsp.hit) begin
			frame = tlb_rsp.frame;
		end else if (mapped) begin
			frame = pm_frame;
		end else begin
			frame = next_frame_q;
		end
	end

	assign next_frame_inc = (next_frame_q == FRAME_W'(FRAME_TOTAL - 1)) ? '0
		: next_frame_q + 1'b1;
	assign next_frame_d   = pm_we ? next_frame_inc : next_frame_q;

	// TLB refill: FIFO, except an eviction rewrites the old page's slot
	always_comb begin
		tlb_upd.fill    = s1_fire && !tlb_rsp.hit
			&& (mapped || !(frames_full_q && tlb_rsp.old_hit));
		tlb_upd.rewrite = pm_we && frames_full_q && tlb_rsp.old_hit;
		tlb_upd.slot    = tlb_rsp.old_slot;
		tlb_upd.page    = page_s1;
		tlb_upd.frame   = frame;
	end

	tlbpt_tlb u_tlb (
		.clk      (clk),
		.arst_n   (arst_n),
		.lk_page  (page_s1),
		.old_page (old_page),
		.upd      (tlb_upd),
		.rsp      (tlb_rsp)
	);

	// Page map frames; valid bits are in flops
	tlbpt_ram #(.WIDTH(FRAME_W), .DEPTH(PAGE_COUNT)) u_page_map (
		.clk   (clk),
		.we    (pm_we),
		.waddr (page_s1),
		.wdata (next_frame_q),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	// Frame owners, read ahead at the next frame to hand out
	tlbpt_ram #(.WIDTH(PAGE_W), .DEPTH(FRAME_TOTAL)) u_frame_owner (
		.clk   (clk),
		.we    (pm_we),
		.waddr (next_frame_q),
		.wdata (page_s1),
		.raddr (next_frame_d),
		.rdata (old_page)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			map_valid_q   <= '0;
			next_frame_q  <= '0;
			frames_full_q <= 1'b0;
			fwd_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			fwd_valid_q  <= pm_we;
			next_frame_q <= next_frame_d;
			if (pm_we) begin
				// evict the previous owner, then map the new page
				if (frames_full_q) begin
					map_valid_q[old_page] <= 1'b0;
				end
				map_valid_q[page_s1] <= 1'b1;
				if (next_frame_inc == '0) begin
					frames_full_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			va_s1 <= req.virtual_address;
		end
		if (pm_we) begin
			fwd_page_q  <= page_s1;
			fwd_frame_q <= next_frame_q;
		end
		if (s1_fire) begin
			pa_s2    <= PA_WIDTH'(pa_full);
			hit_s2   <= tlb_rsp.hit;
			fault_s2 <= fault;
		end
	end

	assign pa_full = {frame, offset_s1};

	assign rsp.valid            = out_valid_q;
	assign rsp.physical_address = pa_s2;
	assign rsp.tlb_hit          = hit_s2;
	assign rsp.fault_flag       = fault_s2;

endmodule

FILE: sim/tlb_page_table_translator_tb.sv
module tlb_page_table_translator_tb;
	import tlbpt_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 800;
	localparam int SEGMENT_LEN  = 100;   // odd segments are sent back to back
	localparam int DRAIN_EVERY  = 150;
	localparam int HOLD_AT      = 320;   // words taken before the long rsp hold-off
	localparam int HOLD_CYCLES  = 60;
	localparam int MAX_GAP      = 5;
	localparam int TAIL_CYCLES  = 10;
	localparam int TIMEOUT      = 2_000_000;

	// Extremes, bit patterns and repeats to show a hit right after a fault
	localparam logic [VA_WIDTH-1:0] DIRECTED [16] = '{
		16'h0000, 16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'h8000,
		16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h0180, 16'hFFFE,
		16'h8000, 16'hAA55, 16'h55AA, 16'h7F80
	};

	typedef struct packed {
		logic [PA_WIDTH-1:0] pa;
		logic                hit;
		logic                fault;
	} xlat_word_t;

	typedef struct {
		logic [VA_WIDTH-1:0] va;
		bit                  drain;    // hold back until every result is in
		int                  max_gap;
	} va_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlbpt_va_if req ();
	tlbpt_pa_if rsp ();

	tlb_page_table_translator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #CLK_HALF clk = ~clk;

	// Shadow translation state
	bit                 tlb_ok  [TLB_ENTRIES];
	logic [PAGE_W-1:0]  tlb_pg  [TLB_ENTRIES];
	logic [FRAME_W-1:0] tlb_frm [TLB_ENTRIES];
	logic [SLOT_W-1:0]  fill_ptr;
	bit                 map_ok  [PAGE_COUNT];
	logic [FRAME_W-1:0] map_frm [PAGE_COUNT];
	logic [PAGE_W-1:0]  owner   [FRAME_TOTAL];
	logic [FRAME_W-1:0] alloc_frame;
	bit                 all_used;

	va_item_t   va_pending [$];
	xlat_word_t pa_expected [$];
	int         errors = 0;
	int         items_queued = 0;
	int         hold_left;
	int         va_taken;

	function automatic int tlb_lookup(logic [PAGE_W-1:0] page);
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (tlb_ok[i] && tlb_pg[i] == page)
				return i;
		end
		return -1;
	endfunction

	function automatic void tlb_fill(logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
		tlb_ok[fill_ptr]  = 1'b1;
		tlb_pg[fill_ptr]  = page;
		tlb_frm[fill_ptr] = frame;
		fill_ptr = SLOT_W'((int'(fill_ptr) + 1) % TLB_ENTRIES);
	endfunction

	// Expected word for one virtual address; advances the shadow state
	function automatic xlat_word_t translate_va(logic [VA_WIDTH-1:0] va);
		logic [PAGE_W-1:0]  page;
		logic [PAGE_W-1:0]  old;
		logic [FRAME_W-1:0] frame;
		int                 slot;
		int                 old_slot;
		xlat_word_t         r;
		page = PAGE_W'((int'(va) >> OFFSET_WIDTH) % PAGE_COUNT);
		slot = tlb_lookup(page);
		r.hit = 1'b0;
		r.fault = 1'b0;
		if (slot >= 0) begin
			frame = tlb_frm[slot];
			r.hit = 1'b1;
		end else if (map_ok[page]) begin
			frame = map_frm[page];
			tlb_fill(page, frame);
		end else begin
			// page fault: round-robin frame, evict its owner once all are used
			r.fault = 1'b1;
			frame = alloc_frame;
			alloc_frame = FRAME_W'((int'(alloc_frame) + 1) % FRAME_TOTAL);
			if (all_used) begin
				old = owner[frame];
				if (map_ok[old] && map_frm[old] == frame)
					map_ok[old] = 1'b0;
				map_ok[page] = 1'b1;
				map_frm[page] = frame;
				old_slot = tlb_lookup(old);
				if (old_slot >= 0) begin
					tlb_pg[old_slot]  = page;
					tlb_frm[old_slot] = frame;
				end else begin
					tlb_fill(page, frame);
				end
			end else begin
				map_ok[page] = 1'b1;
				map_frm[page] = frame;
				tlb_fill(page, frame);
			end
			owner[frame] = page;
			if (alloc_frame == 0)
				all_used = 1'b1;
		end
		r.pa = PA_WIDTH'((int'(frame) << OFFSET_WIDTH) | int'(va[OFFSET_WIDTH-1:0]));
		return r;
	endfunction

	function automatic void queue_va(logic [VA_WIDTH-1:0] va, bit drain);
		va_item_t it;
		it.va = va;
		it.drain = drain;
		it.max_gap = ((items_queued / SEGMENT_LEN) % 2 == 1) ? 0 : MAX_GAP;
		va_pending.push_back(it);
		items_queued++;
	endfunction

	// Known input levels from time zero, then reset and stimulus
	initial begin
		logic [PAGE_W-1:0] hot [8];
		logic [PAGE_W-1:0] warm [40];
		logic [PAGE_W-1:0] pg;
		int                pick;
		req.valid = 1'b0;
		req.virtual_address = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < TLB_ENTRIES; i++)
			tlb_ok[i] = 1'b0;
		for (int i = 0; i < PAGE_COUNT; i++)
			map_ok[i] = 1'b0;
		fill_ptr = '0;
		alloc_frame = '0;
		all_used = 1'b0;

		foreach (DIRECTED[i])
			queue_va(DIRECTED[i], 1'b0);

		// Random part: a hot set for TLB hits, a warm set for resident pages
		// that fell out of the TLB, and fresh pages that fault
		foreach (hot[i])
			hot[i] = PAGE_W'($urandom);
		foreach (warm[i])
			warm[i] = PAGE_W'($urandom);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if ($urandom_range(0, 9) == 0)
				hot[$urandom_range(0, 7)] = warm[$urandom_range(0, 39)];
			if ($urandom_range(0, 19) == 0)
				warm[$urandom_range(0, 39)] = PAGE_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 45)
				pg = hot[$urandom_range(0, 7)];
			else if (pick < 70)
				pg = warm[$urandom_range(0, 39)];
			else
				pg = PAGE_W'($urandom);
			queue_va({pg, OFFSET_WIDTH'($urandom)}, (k % DRAIN_EVERY) == 0);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (va_pending.size() != 0 || req.valid || pa_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#TIMEOUT;
		$display("DONE: errors detected");
		$finish;
	end

	// Request driver: predicts on acceptance, then offers the next word
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.virtual_address <= '0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready)
				pa_expected.push_back(translate_va(req.virtual_address));
			if (!req.valid || req.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (va_pending.size() == 0) begin
					req.valid <= 1'b0;
				end else if (va_pending[0].drain && pa_expected.size() != 0) begin
					req.valid <= 1'b0;
				end else begin
					req.valid <= 1'b1;
					req.virtual_address <= va_pending[0].va;
					gap_left = $urandom_range(0, va_pending[0].max_gap);
					void'(va_pending.pop_front());
				end
			end
		end
	end

	// Long rsp hold-off once, in the middle of a back-to-back segment
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_taken <= 0;
			hold_left <= 0;
		end else begin
			if (req.valid && req.ready)
				va_taken <= va_taken + 1;
			if (req.valid && req.ready && va_taken == HOLD_AT)
				hold_left <= HOLD_CYCLES;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
		end
	end

	// Response monitor: checks each word against the oldest prediction
	int         stall_left;
	int         words_seen;
	xlat_word_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
			words_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pa_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual pa=%h hit=%b fault=%b",
						$time, rsp.physical_address, rsp.tlb_hit, rsp.fault_flag);
				end else begin
					want = pa_expected.pop_front();
					if (rsp.physical_address !== want.pa) begin
						errors++;
						$display("%0t: physical_address expected %h actual %h",
							$time, want.pa, rsp.physical_address);
					end
					if (rsp.tlb_hit !== want.hit) begin
						errors++;
						$display("%0t: tlb_hit expected %b actual %b",
							$time, want.hit, rsp.tlb_hit);
					end
					if (rsp.fault_flag !== want.fault) begin
						errors++;
						$display("%0t: fault_flag expected %b actual %b",
							$time, want.fault, rsp.fault_flag);
					end
				end
				words_seen++;
				stall_left = (words_seen % 160 < 40) ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

endmodule
